### src/lrusa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the lru slot allocator
package lrusa_pkg;

	localparam int KEY_W       = 64;
	localparam int STAMP_W     = 32;
	localparam int OUT_IDX_W   = 6;
	localparam int DEF_SLOTS   = 64;
	localparam int S_DATA_W    = 64;
	localparam int M_DATA_W    = 72;

	typedef enum logic [1:0] {
		FUNC_FIND    = 2'd0,
		FUNC_ASSIGN  = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_TICK    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	// one table row: used flag, last stamp, key
	typedef struct packed {
		logic               used;
		logic [STAMP_W-1:0] stamp;
		logic [KEY_W-1:0]   key;
	} entry_t;

endpackage

### src/lrusa_table.sv
`timescale 1ns / 1ps
// slot table ram: one write port, one registered read port
module lrusa_table #(
	parameter int DEPTH = lrusa_pkg::DEF_SLOTS,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  lrusa_pkg::entry_t     wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output lrusa_pkg::entry_t     rdata
);

	lrusa_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/lru_slot_allocator_frame_guard.sv
`timescale 1ns / 1ps
// top level of the fully associative lru slot allocator
//
// usage
//   input stream (s_*): one beat per request; s_tuser carries func
//   (find, assign, release, frame tick), s_tdata carries the 64-bit key
//   output stream (m_*): exactly one result beat per request, in order
//   m_tuser = {evicted_valid, slot_valid}, m_tdata = {pad, evicted_key, slot_index}
// timing
//   find, assign and release scan the whole table through the single read
//   port of the slot ram, one row a cycle, then pass through the finish state
//   where the result is committed to the output register
//   a frame tick takes no scan: it goes from idle straight to the finish state
//   one request is in flight at a time; s_tready is high only when idle
// reset
//   arst_n clears control state and the frame counter; afterwards a clearing
//   pass writes every row of the ram empty, with s_tready low
// stall
//   the result sits in the output register; a finished request waits for a
//   free output register before it commits its table write
module lru_slot_allocator_frame_guard #(
	parameter int SLOTS = lrusa_pkg::DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [63:0] key
	input  logic [1:0]  s_tuser,  // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [5:0] slot_index, [69:6] evicted_key, [71:70] zero
	output logic [1:0]  m_tuser   // [0] slot_valid, [1] evicted_valid
);

	localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNTW  = IDXW + 1;
	localparam int KW    = lrusa_pkg::KEY_W;
	localparam int SW    = lrusa_pkg::STAMP_W;
	localparam int OW    = lrusa_pkg::OUT_IDX_W;
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(SLOTS - 1);
	localparam logic [CNTW-1:0] CNT_END  = CNTW'(SLOTS);
	localparam logic [IDXW-1:0] IDX_LAST = IDXW'(SLOTS - 1);

	lrusa_pkg::state_t state_q, state_nx;

	// request registers
	lrusa_pkg::func_t  func_q;
	logic [KW-1:0]     key_q;
	logic [SW-1:0]     frame_q;
	logic [CNTW-1:0]   cnt_q;

	// read pipeline
	logic              rvld_s1;
	logic [IDXW-1:0]   ridx_s1;
	lrusa_pkg::entry_t rdata;

	// scan results
	logic              hit_q, free_q, vic_q;
	logic [IDXW-1:0]   hit_idx_q, free_idx_q, vic_idx_q;
	logic [SW-1:0]     vic_stamp_q;
	logic [KW-1:0]     vic_key_q;

	// output register
	logic              m_valid_q;
	logic [OW-1:0]     o_idx_q;
	logic [KW-1:0]     o_evkey_q;
	logic              o_sv_q, o_ev_q;

	// control
	logic              accept, out_free, commit;
	logic              rd_en, wr_en;
	logic [IDXW-1:0]   rd_addr, wr_addr;
	lrusa_pkg::entry_t wr_data;
	logic              res_sv, res_ev, res_we, res_used;
	logic [IDXW-1:0]   res_idx;
	logic [KW-1:0]     res_evkey;
	logic [IDXW+OW-1:0] idx_ext;
	logic              scan_last;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign scan_last = rvld_s1 && (ridx_s1 == IDX_LAST);

	lrusa_table #(
		.DEPTH (SLOTS),
		.AW    (IDXW)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lrusa_pkg::ST_CLEAR: begin
				if (cnt_q == CNT_LAST) begin
					state_nx = lrusa_pkg::ST_IDLE;
				end
			end
			lrusa_pkg::ST_IDLE: begin
				if (accept) begin
					state_nx = (lrusa_pkg::func_t'(s_tuser) == lrusa_pkg::FUNC_TICK)
						? lrusa_pkg::ST_FIN : lrusa_pkg::ST_SCAN;
				end
			end
			lrusa_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_nx = lrusa_pkg::ST_FIN;
				end
			end
			lrusa_pkg::ST_FIN: begin
				if (out_free) begin
					state_nx = lrusa_pkg::ST_IDLE;
				end
			end
			default: state_nx = lrusa_pkg::ST_CLEAR;
		endcase
	end

	// result decision at the end of a request
	always_comb begin
		res_sv    = 1'b0;
		res_ev    = 1'b0;
		res_we    = 1'b0;
		res_used  = 1'b1;
		res_idx   = hit_idx_q;
		res_evkey = '0;
		unique case (func_q)
			lrusa_pkg::FUNC_TICK: begin
			end
			lrusa_pkg::FUNC_RELEASE: begin
				res_we   = hit_q;
				res_used = 1'b0;
			end
			lrusa_pkg::FUNC_FIND: begin
				res_we = hit_q;
				res_sv = hit_q;
			end
			lrusa_pkg::FUNC_ASSIGN: begin
				priority if (hit_q) begin
					res_we = 1'b1;
					res_sv = 1'b1;
				end else if (free_q) begin
					res_we  = 1'b1;
					res_sv  = 1'b1;
					res_idx = free_idx_q;
				end else if (vic_q) begin
					res_we    = 1'b1;
					res_sv    = 1'b1;
					res_ev    = 1'b1;
					res_idx   = vic_idx_q;
					res_evkey = vic_key_q;
				end else begin
					// every slot stamped this frame: nothing to evict
				end
			end
			default: begin
			end
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = cnt_q[IDXW-1:0];
		wr_en    = 1'b0;
		wr_addr  = cnt_q[IDXW-1:0];
		wr_data  = '0;
		commit   = 1'b0;
		unique case (state_q)
			lrusa_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			lrusa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			lrusa_pkg::ST_SCAN: begin
				rd_en = (cnt_q < CNT_END);
			end
			lrusa_pkg::ST_FIN: begin
				commit        = out_free;
				wr_en         = out_free && res_we;
				wr_addr       = res_idx;
				wr_data.used  = res_used;
				wr_data.stamp = frame_q;
				wr_data.key   = key_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrusa_pkg::ST_CLEAR;
			cnt_q   <= '0;
			rvld_s1 <= 1'b0;
			frame_q <= '0;
		end else begin
			state_q <= state_nx;
			rvld_s1 <= rd_en;
			if (accept) begin
				cnt_q <= '0;
			end else if ((state_q == lrusa_pkg::ST_CLEAR) || rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// frame counter saturates at all ones
			if (commit && (func_q == lrusa_pkg::FUNC_TICK) && (frame_q != '1)) begin
				frame_q <= frame_q + 1'b1;
			end
		end
	end

	// request capture and scan accumulation
	always_ff @(posedge clk) begin
		ridx_s1 <= rd_addr;
		if (accept) begin
			func_q <= lrusa_pkg::func_t'(s_tuser);
			key_q  <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			vic_q  <= 1'b0;
		end else if (accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			vic_q  <= 1'b0;
		end else if (rvld_s1) begin
			// first used row with the key
			if (!hit_q && rdata.used && (rdata.key == key_q)) begin
				hit_q <= 1'b1;
			end
			// lowest free row
			if (!free_q && !rdata.used) begin
				free_q <= 1'b1;
			end
			// oldest stamp before this frame, ties to the lower index
			if ((rdata.stamp < frame_q) && (!vic_q || (rdata.stamp < vic_stamp_q))) begin
				vic_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1) begin
			if (!hit_q && rdata.used && (rdata.key == key_q)) begin
				hit_idx_q <= ridx_s1;
			end
			if (!free_q && !rdata.used) begin
				free_idx_q <= ridx_s1;
			end
			if ((rdata.stamp < frame_q) && (!vic_q || (rdata.stamp < vic_stamp_q))) begin
				vic_idx_q   <= ridx_s1;
				vic_stamp_q <= rdata.stamp;
				vic_key_q   <= rdata.key;
			end
		end
	end

	// output register
	assign idx_ext = {{OW{1'b0}}, res_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			o_sv_q    <= res_sv;
			o_ev_q    <= res_ev;
			o_idx_q   <= res_sv ? idx_ext[OW-1:0] : '0;
			o_evkey_q <= res_evkey;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, o_evkey_q, o_idx_q};
	assign m_tuser  = {o_ev_q, o_sv_q};

	// checks
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrusa_pkg::ST_SCAN) |-> !wr_en)
		else $error("table written during scan");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((state_q == lrusa_pkg::ST_SCAN) || (state_q == lrusa_pkg::ST_FIN)))
		else $error("accepted beat not taken into work");

	a_evict_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (!o_ev_q || o_sv_q))
		else $error("eviction reported without a slot");

	a_frame_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> (frame_q == $past(frame_q)))
		else $error("frame counter moved outside a tick");

endmodule

### tb/lru_slot_allocator_frame_guard_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the lru slot allocator with its own table predictor
module lru_slot_allocator_frame_guard_test;

	localparam int SLOTS           = lrusa_pkg::DEF_SLOTS;
	localparam int KEY_POOL        = 96;     // a little over the table size, so it fills and evicts
	localparam int PRESSURE_CYCLES = 400;    // long output hold-off
	localparam int WATCHDOG_LIMIT  = 5000;   // cycles with no beat on either side
	localparam int MIXED_PER_PHASE = 140;
	localparam int KW              = lrusa_pkg::KEY_W;
	localparam int SW              = lrusa_pkg::STAMP_W;

	// one result beat, unpacked
	typedef struct packed {
		logic          slot_valid;
		logic [5:0]    slot_index;
		logic          evicted_valid;
		logic [KW-1:0] evicted_key;
	} alloc_result_t;

	// mirror of the slot table plus the queue of results still owed by the block
	class slot_allocation_board;
		logic [KW-1:0] key_of[SLOTS];
		bit            used[SLOTS];
		logic [SW-1:0] stamp_of[SLOTS];
		logic [SW-1:0] frame;
		alloc_result_t owed_results[$];
		int mismatches;
		int n_find, n_find_hit, n_assign, n_assign_hit, n_evict, n_refused, n_release, n_tick;

		function new();
			frame = '0;
			mismatches = 0;
			foreach (used[i]) begin
				used[i] = 1'b0;
				key_of[i] = '0;
				stamp_of[i] = '0;
			end
		endfunction

		// keys are unique among used slots, so the first match is the only one
		function int slot_of_key(logic [KW-1:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && key_of[i] == k)
					return i;
			return -1;
		endfunction

		// work out the result of one accepted request and update the mirror
		function void predict_request(lrusa_pkg::func_t f, logic [KW-1:0] k);
			alloc_result_t r;
			int hit;
			int pick;
			r = '0;
			pick = -1;
			case (f)
				lrusa_pkg::FUNC_TICK: begin
					n_tick++;
					// frame counter saturates at all ones
					if (frame != '1)
						frame++;
				end
				lrusa_pkg::FUNC_RELEASE: begin
					n_release++;
					hit = slot_of_key(k);
					if (hit >= 0)
						used[hit] = 1'b0;
				end
				default: begin
					if (f == lrusa_pkg::FUNC_FIND)
						n_find++;
					else
						n_assign++;
					hit = slot_of_key(k);
					if (hit >= 0) begin
						// find hit or assign of a present key: restamp, never evict
						stamp_of[hit] = frame;
						r.slot_valid = 1'b1;
						r.slot_index = hit[5:0];
						if (f == lrusa_pkg::FUNC_FIND)
							n_find_hit++;
						else
							n_assign_hit++;
					end else if (f == lrusa_pkg::FUNC_ASSIGN) begin
						for (int i = 0; i < SLOTS && pick < 0; i++)
							if (!used[i])
								pick = i;
						if (pick < 0) begin
							// full table: oldest stamp strictly before this frame, lowest index on ties
							for (int i = 0; i < SLOTS; i++)
								if (stamp_of[i] < frame && (pick < 0 || stamp_of[i] < stamp_of[pick]))
									pick = i;
							if (pick >= 0) begin
								r.evicted_valid = 1'b1;
								r.evicted_key = key_of[pick];
								n_evict++;
							end else begin
								n_refused++;
							end
						end
						if (pick >= 0) begin
							key_of[pick] = k;
							used[pick] = 1'b1;
							stamp_of[pick] = frame;
							r.slot_valid = 1'b1;
							r.slot_index = pick[5:0];
						end
					end
				end
			endcase
			owed_results = {owed_results, r};
		endfunction

		// compare one accepted result beat with the oldest owed result
		function void check_result(logic [1:0] tuser, logic [lrusa_pkg::M_DATA_W-1:0] tdata);
			alloc_result_t got;
			alloc_result_t want;
			got.slot_valid    = tuser[0];
			got.evicted_valid = tuser[1];
			got.slot_index    = tdata[5:0];
			got.evicted_key   = tdata[69:6];
			if (tdata[71:70] != 2'b00) begin
				mismatches++;
				$display("%0t: tdata padding expected 0 actual %0h", $time, tdata[71:70]);
			end
			if (owed_results.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing expected: tuser %0h tdata %0h",
					$time, tuser, tdata);
				return;
			end
			want = owed_results.pop_front();
			if (got.slot_valid !== want.slot_valid) begin
				mismatches++;
				$display("%0t: slot_valid expected %0b actual %0b", $time,
					want.slot_valid, got.slot_valid);
			end
			if (got.slot_index !== want.slot_index) begin
				mismatches++;
				$display("%0t: slot_index expected %0d actual %0d", $time,
					want.slot_index, got.slot_index);
			end
			if (got.evicted_valid !== want.evicted_valid) begin
				mismatches++;
				$display("%0t: evicted_valid expected %0b actual %0b", $time,
					want.evicted_valid, got.evicted_valid);
			end
			if (got.evicted_key !== want.evicted_key) begin
				mismatches++;
				$display("%0t: evicted_key expected %h actual %h", $time,
					want.evicted_key, got.evicted_key);
			end
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [lrusa_pkg::S_DATA_W-1:0]      s_tdata = '0;
	logic [1:0]                          s_tuser = lrusa_pkg::FUNC_FIND;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [lrusa_pkg::M_DATA_W-1:0]      m_tdata;
	logic [1:0]                          m_tuser;

	slot_allocation_board board = new();
	logic [KW-1:0] key_pool[KEY_POOL];
	int src_idle_pct = 0;       // chance per cycle that the sender holds back
	int snk_idle_pct = 0;       // chance per cycle that the receiver stalls
	int pressure_asked = 0;     // bumped by the stimulus to request a long hold-off
	int pressure_served = 0;    // owned by the receiver process
	int hold_left = 0;
	int quiet_cycles = 0;

	lru_slot_allocator_frame_guard #(
		.SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // [63:0] key
		.s_tuser(s_tuser),   // [1:0] func
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),   // [5:0] slot_index, [69:6] evicted_key, [71:70] zero
		.m_tuser(m_tuser)    // [0] slot_valid, [1] evicted_valid
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: ready changes on the falling edge; a pressure request holds it low for a
	// long stretch so the result register stays full and the block stalls its input
	always @(negedge clk) begin
		if (hold_left == 0 && pressure_served != pressure_asked) begin
			hold_left = PRESSURE_CYCLES;
			pressure_served++;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// result beats are taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tuser, m_tdata);
	end

	// watchdog: a long run of cycles with no beat on either side ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
				quiet_cycles, board.owed_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	// one request beat; called at a falling edge, returns at a falling edge
	// valid is only lowered when a gap is rolled, so back-to-back beats keep it high
	task automatic send_request(input lrusa_pkg::func_t f, input logic [KW-1:0] k);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= k;
		do
			@(posedge clk);
		while (!s_tready);
		board.predict_request(f, k);
		@(negedge clk);
	endtask

	// a tick, then more fresh assigns than slots: fills free slots, evicts older frames
	// (ties on the lowest index) and finally hits a table stamped entirely this frame
	task automatic fill_burst();
		send_request(lrusa_pkg::FUNC_TICK, {$urandom, $urandom});
		repeat (SLOTS + 6)
			send_request(lrusa_pkg::FUNC_ASSIGN, {$urandom, $urandom});
	endtask

	// mostly pool keys so finds and releases hit, some fully random keys for bit toggling
	task automatic mixed_request();
		int pick;
		logic [KW-1:0] k;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 85)
			k = key_pool[$urandom_range(KEY_POOL - 1)];
		else
			k = {$urandom, $urandom};
		if (pick < 25)
			send_request(lrusa_pkg::FUNC_FIND, k);
		else if (pick < 65)
			send_request(lrusa_pkg::FUNC_ASSIGN, k);
		else if (pick < 80)
			send_request(lrusa_pkg::FUNC_RELEASE, k);
		else
			send_request(lrusa_pkg::FUNC_TICK, k);
	endtask

	initial begin
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;

		// hold reset, release it at a falling edge; the block then clears its table with s_tready low
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: key extremes, every func, hits, misses and releases
		send_request(lrusa_pkg::FUNC_FIND, 64'd0);                      // miss on an empty table
		send_request(lrusa_pkg::FUNC_ASSIGN, 64'd0);                    // lowest free slot
		send_request(lrusa_pkg::FUNC_ASSIGN, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(lrusa_pkg::FUNC_FIND, 64'hFFFF_FFFF_FFFF_FFFF);    // hit
		send_request(lrusa_pkg::FUNC_ASSIGN, 64'd0);                    // assign of a present key
		send_request(lrusa_pkg::FUNC_RELEASE, 64'h5555_5555_5555_5555); // release of an absent key
		send_request(lrusa_pkg::FUNC_RELEASE, 64'd0);
		send_request(lrusa_pkg::FUNC_FIND, 64'd0);                      // miss after release
		send_request(lrusa_pkg::FUNC_ASSIGN, 64'hAAAA_AAAA_AAAA_AAAA);  // reuses the freed slot
		send_request(lrusa_pkg::FUNC_TICK, 64'd0);
		send_request(lrusa_pkg::FUNC_FIND, 64'hFFFF_FFFF_FFFF_FFFF);    // restamp in a later frame
		send_request(lrusa_pkg::FUNC_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(lrusa_pkg::FUNC_TICK, 64'h8000_0000_0000_0001);
		send_request(lrusa_pkg::FUNC_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(lrusa_pkg::FUNC_ASSIGN, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(lrusa_pkg::FUNC_FIND, 64'h8000_0000_0000_0000);
		send_request(lrusa_pkg::FUNC_ASSIGN, 64'd1);

		// random phases: no idling, idle sender, stalling receiver, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
				1: begin src_idle_pct = 58; snk_idle_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_idle_pct = 58; end
				default: begin src_idle_pct = 28; snk_idle_pct = 28; end
			endcase
			// long output hold-off while the sender keeps offering
			if (ph == 1)
				pressure_asked++;
			fill_burst();
			repeat (MIXED_PER_PHASE)
				mixed_request();
		end
		s_tvalid <= 1'b0;

		// drain, then give a late or extra result time to show up
		while (board.owed_results.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		$display("covered %0d finds (%0d hits), %0d assigns (%0d on present keys, %0d evictions,",
			board.n_find, board.n_find_hit, board.n_assign, board.n_assign_hit, board.n_evict);
		$display("  %0d refused on a full current frame), %0d releases, %0d frame ticks",
			board.n_refused, board.n_release, board.n_tick);
		if (board.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### lru_slot_allocator_frame_guard.f
src/lrusa_pkg.sv
src/lrusa_table.sv
src/lru_slot_allocator_frame_guard.sv
tb/lru_slot_allocator_frame_guard_test.sv
